### rtl/trca_pkg.sv
// Package for the throughput rank cache admission block.
// Holds widths, history depth, decision constants, the controller state type
// and the command/status structs. Used by the controller, datapath and top.
package trca_pkg;

  // Field widths fixed by the interface.
  localparam int BYTES_W = 40;
  localparam int DUR_W   = 32;
  localparam int TP_W    = 50;
  localparam int INCR_W  = 2;

  // History ring sizing; everything below follows from the depth.
  localparam int HISTORY_DEPTH = 64;
  localparam int IDX_W  = $clog2(HISTORY_DEPTH);
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = TP_W + IDX_W;

  // Divider step counter, one quotient bit per step.
  localparam int STEP_W = $clog2(TP_W + 1);

  // Decision constants.
  localparam int RICH_MIN = 6;
  localparam int CUT_LO   = 16;
  localparam int CUT_HI   = 33;
  localparam int PCT      = 100;
  localparam int SPARSE_NUM = 5;
  localparam int SPARSE_N_W = 3;
  localparam int MUL_N_W  = 6;
  localparam int CMP_W    = TP_W + MUL_N_W;
  localparam int RANK_W   = CNT_W + 7;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPDATE,
    ST_SCAN,
    ST_FINISH
  } trca_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic update;
    logic scan;
    logic load_out;
  } trca_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic rank_go;
    logic scan_done;
  } trca_status_t;

endpackage

### rtl/throughput_rank_cache_admission.sv
// Top level of the throughput rank cache admission block.
// Instantiates the controller (trca_ctrl) and datapath (trca_dp); uses trca_pkg.
//
// Usage: each input transaction (in_byte_count, in_duration_ms,
// in_reuse_request) is taken when in_valid is high and in_stall is low, and
// gives exactly one output transaction (out_should_cache,
// out_priority_increment, out_throughput_bps) under out_valid/out_stall.
// One item is processed at a time. The serial divider for bytes*1000/duration
// produces the 50 quotient bits in turn and then sees that it has finished;
// the update state then writes the history ring, count and sum. With reuse and
// at least six samples, a rank scan reads one sample per cycle. Finally the
// output register is loaded once it is free; in_stall drops as out_valid rises.
// A new item may be accepted while the previous result still waits in the
// output register; if the receiver keeps stalling, the next result is held
// back until the register drains, and intake stops until then.
// Synchronous active-low reset empties the history (count, slot, sum) and
// clears out_valid; history contents need no clearing.
module throughput_rank_cache_admission (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [trca_pkg::BYTES_W-1:0]   in_byte_count,
  input  logic [trca_pkg::DUR_W-1:0]     in_duration_ms,
  input  logic                           in_reuse_request,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_should_cache,
  output logic [trca_pkg::INCR_W-1:0]    out_priority_increment,
  output logic [trca_pkg::TP_W-1:0]      out_throughput_bps
);
  import trca_pkg::*;

  trca_cmd_t    cmd;
  trca_status_t status;

  // Sequencing.
  trca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Arithmetic and history storage.
  trca_dp u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_byte_count          (in_byte_count),
    .in_duration_ms         (in_duration_ms),
    .in_reuse_request       (in_reuse_request),
    .cmd                    (cmd),
    .status                 (status),
    .out_should_cache       (out_should_cache),
    .out_priority_increment (out_priority_increment),
    .out_throughput_bps     (out_throughput_bps)
  );

  // An accepted item blocks intake until its processing is done.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in progress");

  // A result is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("output register overwritten before transfer");

  // A new output transaction appears only after a load command.
  a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.load_out))
    else $error("output valid raised without a result load");

  // The divider never steps past its last quotient bit.
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> !status.div_done)
    else $error("divider stepped after completion");

endmodule

### rtl/trca_ctrl.sv
// Controller state machine for the throughput rank cache admission block.
// Sequences divide, history update, rank scan and output load; owns out_valid.
// Depends on trca_pkg.
module trca_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  logic                  out_stall,
  input  trca_pkg::trca_status_t status,
  output trca_pkg::trca_cmd_t    cmd
);
  import trca_pkg::*;

  trca_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || !out_stall;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        state_nxt = status.rank_go ? ST_SCAN : ST_FINISH;
      end
      ST_SCAN: begin
        if (status.scan_done) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Commands and handshake outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      // The divider stops once the last quotient bit is in.
      ST_DIV:    cmd.div_step = !status.div_done;
      ST_UPDATE: cmd.update   = 1'b1;
      ST_SCAN:   cmd.scan     = 1'b1;
      ST_FINISH: cmd.load_out = out_free;
      default:   cmd          = '0;
    endcase
  end

  // Output valid is set on a load and cleared when the transaction completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/trca_dp.sv
// Datapath for the throughput rank cache admission block.
// Holds the serial divider, the history memory with its count, slot and sum,
// the rank scan and the output register. Depends on trca_pkg.
module trca_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [trca_pkg::BYTES_W-1:0]   in_byte_count,
  input  logic [trca_pkg::DUR_W-1:0]     in_duration_ms,
  input  logic                           in_reuse_request,
  input  trca_pkg::trca_cmd_t            cmd,
  output trca_pkg::trca_status_t         status,
  output logic                           out_should_cache,
  output logic [trca_pkg::INCR_W-1:0]    out_priority_increment,
  output logic [trca_pkg::TP_W-1:0]      out_throughput_bps
);
  import trca_pkg::*;

  // Item registers.
  logic [TP_W-1:0]   qd_r;
  logic [DUR_W-1:0]  rem_r;
  logic [DUR_W-1:0]  dvsr_r;
  logic [STEP_W-1:0] step_r;
  logic              reuse_r;

  // History state.
  logic [TP_W-1:0]   hist_mem [HISTORY_DEPTH];
  logic [TP_W-1:0]   rd_data_r;
  logic [CNT_W-1:0]  count_r;
  logic [IDX_W-1:0]  slot_r;
  logic [SUM_W-1:0]  sum_r;

  // Scan and sparse-check registers.
  logic [CNT_W-1:0]  issue_r;
  logic              pend_r;
  logic [CNT_W-1:0]  hit_r;
  logic [CMP_W-1:0]  prod_r;

  // Output register.
  logic              cache_r;
  logic [INCR_W-1:0] incr_r;
  logic [TP_W-1:0]   tp_r;

  logic [TP_W-1:0]   dividend;
  logic [DUR_W:0]    rem_shift;
  logic              q_bit;
  logic [TP_W-1:0]   t_val;
  logic              full;
  logic [CNT_W-1:0]  n_after;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [SPARSE_N_W-1:0] n_small;
  logic [MUL_N_W-1:0] five_n;
  logic [CMP_W-1:0]  sum4;
  logic [RANK_W-1:0] hit100, lo_cut, hi_cut;
  logic              rank_mode;
  logic              cache_val;
  logic [INCR_W-1:0] incr_val;

  // Dividend is byte_count * 1000 = b*1024 - b*16 - b*8.
  assign dividend = {in_byte_count, 10'b0} - TP_W'({in_byte_count, 4'b0})
                    - TP_W'({in_byte_count, 3'b0});

  // One restoring divide step: shift in the next dividend bit.
  assign rem_shift = {rem_r, qd_r[TP_W-1]};
  assign q_bit     = rem_shift >= {1'b0, dvsr_r};

  // A zero duration yields zero throughput.
  assign t_val = (dvsr_r == '0) ? '0 : qd_r;

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      qd_r    <= dividend;
      rem_r   <= '0;
      dvsr_r  <= in_duration_ms;
      step_r  <= '0;
      reuse_r <= in_reuse_request;
    end else if (cmd.div_step) begin
      rem_r  <= q_bit ? DUR_W'(rem_shift - {1'b0, dvsr_r}) : DUR_W'(rem_shift);
      qd_r   <= {qd_r[TP_W-2:0], q_bit};
      step_r <= step_r + 1'b1;
    end
  end

  assign full    = (count_r == CNT_W'(HISTORY_DEPTH));
  assign n_after = full ? count_r : count_r + 1'b1;

  // History bookkeeping: count, write slot and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      slot_r  <= '0;
      sum_r   <= '0;
    end else if (cmd.update) begin
      count_r <= n_after;
      slot_r  <= (slot_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
      sum_r   <= sum_r - (full ? SUM_W'(rd_data_r) : '0) + SUM_W'(t_val);
    end
  end

  // Memory read address: the slot being replaced at accept, then the scan.
  assign rd_en   = cmd.accept || (cmd.scan && (issue_r < count_r));
  assign rd_addr = cmd.accept ? slot_r : issue_r[IDX_W-1:0];

  // History memory write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      hist_mem[slot_r] <= t_val;
    end
    if (rd_en) begin
      rd_data_r <= hist_mem[rd_addr];
    end
  end

  // Sparse check term 5*n*t, only meaningful while n is below six.
  assign n_small = n_after[SPARSE_N_W-1:0];
  assign five_n  = MUL_N_W'(n_small) * MUL_N_W'(SPARSE_NUM);

  // Rank scan: one sample read per cycle, compared in the cycle after its read.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      issue_r <= '0;
      pend_r  <= 1'b0;
      hit_r   <= '0;
      prod_r  <= CMP_W'(t_val) * CMP_W'(five_n);
    end else if (cmd.scan) begin
      pend_r <= issue_r < count_r;
      if (issue_r < count_r) begin
        issue_r <= issue_r + 1'b1;
      end
      if (pend_r && (rd_data_r <= t_val)) begin
        hit_r <= hit_r + 1'b1;
      end
    end
  end

  // Decision from the rank count or from the sparse mean check; without reuse nothing is cached.
  assign rank_mode = reuse_r && (count_r >= CNT_W'(RICH_MIN));
  assign sum4      = CMP_W'({sum_r, 2'b00});
  assign hit100    = RANK_W'(hit_r) * RANK_W'(PCT);
  assign lo_cut    = RANK_W'(count_r - 1'b1) * RANK_W'(CUT_LO);
  assign hi_cut    = RANK_W'(count_r - 1'b1) * RANK_W'(CUT_HI);

  always_comb begin
    cache_val = 1'b0;
    incr_val  = '0;
    if (rank_mode) begin
      if (hit100 > lo_cut) incr_val = incr_val + INCR_W'(2);
      if (hit100 > hi_cut) begin
        incr_val  = incr_val + INCR_W'(1);
        cache_val = 1'b1;
      end
    end else if (reuse_r) begin
      cache_val = prod_r >= sum4;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cache_r <= cache_val;
      incr_r  <= incr_val;
      tp_r    <= t_val;
    end
  end

  assign status.div_done  = (step_r == STEP_W'(TP_W));
  assign status.rank_go   = reuse_r && (n_after >= CNT_W'(RICH_MIN));
  assign status.scan_done = (issue_r == count_r) && !pend_r;

  assign out_should_cache       = cache_r;
  assign out_priority_increment = incr_r;
  assign out_throughput_bps     = tp_r;

endmodule
